// ===== src/iic_pkg.sv =====
`timescale 1ns / 1ps

package iic_pkg;

  localparam int PIX_W      = 8;
  localparam int FRAC_W     = 8;
  localparam int DARK_W     = 26;
  localparam int WEIGHT_W   = 35;
  localparam int CENT_W     = 18;
  localparam int QUO_W      = WEIGHT_W + FRAC_W;
  localparam int STEP_W     = $clog2(QUO_W);
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0]  CFG_AXIS_SELECT = 1'b0;
  localparam logic [CFG_IDX_W-1:0]  CFG_ROW_WIDTH   = 1'b1;
  localparam logic [CFG_DATA_W-1:0] ROW_WIDTH_RESET = 10'd64;
  localparam logic [STEP_W-1:0]     LAST_STEP       = STEP_W'(QUO_W - 1);

  typedef enum logic [1:0] {
    ST_ACCUM,
    ST_DIVIDE,
    ST_DONE
  } iic_state_e;

  typedef struct packed {
    logic accept;
    logic start_div;
    logic div_step;
    logic load_out;
  } iic_cmd_t;

  typedef struct packed {
    logic div_last;
  } iic_status_t;

endpackage

// ===== src/iic_if.sv =====
`timescale 1ns / 1ps

interface iic_pixel_if;
  logic                      valid;
  logic                      ready;
  logic [iic_pkg::PIX_W-1:0] intensity;
  logic                      frame_last;

  modport source (output valid, output intensity, output frame_last, input ready);
  modport sink   (input valid, input intensity, input frame_last, output ready);
endinterface

interface iic_result_if;
  logic                       valid;
  logic                       ready;
  logic [iic_pkg::CENT_W-1:0] centroid_q8;
  logic                       empty_frame;

  modport source (output valid, output centroid_q8, output empty_frame, input ready);
  modport sink   (input valid, input centroid_q8, input empty_frame, output ready);
endinterface

interface iic_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [iic_pkg::CFG_IDX_W-1:0]  index;
  logic [iic_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/inverted_intensity_centroid.sv =====
`timescale 1ns / 1ps

// Inverted intensity centroid. Pixels of a frame arrive in raster order on pix_i; each
// weighs 255 minus its intensity, and the block sums that darkness and the darkness
// times the one-based column (axis_select 0) or row (axis_select 1), tracking position
// with row_width. Within a frame a pixel is taken every cycle. The pixel marked
// frame_last closes the frame: the sums go to a restoring divider that yields one
// quotient bit per cycle over 43 divider steps, then loads the result; throughout,
// pix_i is not ready, and the load waits longer while an earlier result has not been
// taken. The result is the centroid in unsigned Q.8, truncated and capped at
// MAX_DIM * 256; an all-white frame gives 0 with empty_frame set. The result sits
// in an output register, so the next frame streams in while it waits to be taken.
// Configuration writes are always accepted.
module inverted_intensity_centroid #(
  parameter int MAX_DIM = 512
) (
  input logic    clk_i,
  input logic    rst_ni,
  iic_pixel_if.sink    pix_i,
  iic_result_if.source res_o,
  iic_cfg_if.sink      cfg_i
);
  import iic_pkg::*;

  iic_cmd_t    cmd;
  iic_status_t status;

  assign cfg_i.ready = 1'b1;

  iic_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_valid_i (pix_i.valid),
    .pix_last_i  (pix_i.frame_last),
    .pix_ready_o (pix_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  iic_datapath #(
    .MAX_DIM (MAX_DIM)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_i.valid),
    .cfg_index_i   (cfg_i.index),
    .cfg_data_i    (cfg_i.data),
    .intensity_i   (pix_i.intensity),
    .cmd_i         (cmd),
    .status_o      (status),
    .centroid_q8_o (res_o.centroid_q8),
    .empty_frame_o (res_o.empty_frame)
  );

endmodule

// ===== src/iic_ctrl.sv =====
`timescale 1ns / 1ps

module iic_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 pix_valid_i,
  input  logic                 pix_last_i,
  output logic                 pix_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  iic_pkg::iic_status_t status_i,
  output iic_pkg::iic_cmd_t    cmd_o
);
  import iic_pkg::*;

  iic_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ACCUM;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    pix_ready_o     = 1'b0;
    cmd_o           = '0;
    fire            = 1'b0;
    case (state_q)
      ST_ACCUM: begin
        pix_ready_o     = 1'b1;
        fire            = pix_valid_i;
        cmd_o.accept    = fire;
        cmd_o.start_div = fire & pix_last_i;
        if (cmd_o.start_div) begin
          state_d = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        cmd_o.load_out = !out_valid_q || out_ready_i;
        if (cmd_o.load_out) begin
          state_d = ST_ACCUM;
        end
      end
      default: begin
        state_d = ST_ACCUM;
      end
    endcase

    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== src/iic_datapath.sv =====
`timescale 1ns / 1ps

module iic_datapath #(
  parameter int MAX_DIM = 512
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [iic_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [iic_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic [iic_pkg::PIX_W-1:0]      intensity_i,
  input  iic_pkg::iic_cmd_t              cmd_i,
  output iic_pkg::iic_status_t           status_o,
  output logic [iic_pkg::CENT_W-1:0]     centroid_q8_o,
  output logic                           empty_frame_o
);
  import iic_pkg::*;

  localparam int CW   = $clog2(MAX_DIM);
  localparam int EW   = (CW + 1 > CFG_DATA_W) ? CW + 1 : CFG_DATA_W;
  localparam int PW   = PIX_W + CW + 1;
  localparam logic [EW-1:0]    MAX_DIM_E = EW'(MAX_DIM);
  localparam logic [CW:0]      MAX_DIM_R = (CW + 1)'(MAX_DIM);
  localparam logic [QUO_W-1:0] CAP       = QUO_W'(MAX_DIM) << FRAC_W;

  logic                  axis_q;
  logic [CFG_DATA_W-1:0] row_width_q;
  logic [CW-1:0]         col_q, row_q;
  logic [DARK_W-1:0]     dark_sum_q;
  logic [WEIGHT_W-1:0]   weight_sum_q;

  logic [PIX_W-1:0]      dark;
  logic [CW:0]           coord;
  logic [PW-1:0]         prod;
  logic [DARK_W:0]       dark_add;
  logic [WEIGHT_W:0]     weight_add;
  logic [DARK_W-1:0]     dark_sat;
  logic [WEIGHT_W-1:0]   weight_sat;
  logic [EW-1:0]         width_eff, col_next;
  logic [CW:0]           row_next;

  logic [DARK_W-1:0]     divisor_q;
  logic [DARK_W-1:0]     rem_q;
  logic [QUO_W-1:0]      quo_q;
  logic [STEP_W-1:0]     step_q;
  logic                  empty_q;
  logic [DARK_W:0]       trial;
  logic                  trial_ge;
  logic [QUO_W-1:0]      quo_clamp;
  logic [CENT_W-1:0]     cent_q;
  logic                  cent_empty_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_q      <= 1'b0;
      row_width_q <= ROW_WIDTH_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_AXIS_SELECT: axis_q      <= cfg_data_i[0];
        CFG_ROW_WIDTH:   row_width_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    dark       = ~intensity_i;
    coord      = (axis_q ? {1'b0, row_q} : {1'b0, col_q}) + (CW + 1)'(1);
    prod       = PW'(dark) * PW'(coord);
    dark_add   = {1'b0, dark_sum_q} + (DARK_W + 1)'(dark);
    weight_add = {1'b0, weight_sum_q} + (WEIGHT_W + 1)'(prod);
    dark_sat   = dark_add[DARK_W] ? '1 : dark_add[DARK_W-1:0];
    weight_sat = weight_add[WEIGHT_W] ? '1 : weight_add[WEIGHT_W-1:0];

    width_eff = EW'(row_width_q);
    if (width_eff == '0) begin
      width_eff = EW'(1);
    end
    if (width_eff > MAX_DIM_E) begin
      width_eff = MAX_DIM_E;
    end
    col_next = EW'(col_q) + EW'(1);
    row_next = {1'b0, row_q} + (CW + 1)'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q        <= '0;
      row_q        <= '0;
      dark_sum_q   <= '0;
      weight_sum_q <= '0;
    end else if (cmd_i.start_div) begin
      col_q        <= '0;
      row_q        <= '0;
      dark_sum_q   <= '0;
      weight_sum_q <= '0;
    end else if (cmd_i.accept) begin
      dark_sum_q   <= dark_sat;
      weight_sum_q <= weight_sat;
      if (col_next >= width_eff) begin
        col_q <= '0;
        row_q <= (row_next >= MAX_DIM_R) ? '0 : row_next[CW-1:0];
      end else begin
        col_q <= col_next[CW-1:0];
      end
    end
  end

  // restoring divider, one quotient bit per cycle
  always_comb begin
    trial    = {rem_q, quo_q[QUO_W-1]};
    trial_ge = trial >= {1'b0, divisor_q};
    quo_clamp = (quo_q > CAP) ? CAP : quo_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (cmd_i.start_div) begin
      step_q <= '0;
    end else if (cmd_i.div_step) begin
      step_q <= step_q + STEP_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_div) begin
      divisor_q <= dark_sat;
      rem_q     <= '0;
      quo_q     <= {weight_sat, FRAC_W'(0)};
      empty_q   <= (dark_sat == '0);
    end else if (cmd_i.div_step) begin
      rem_q <= trial_ge ? DARK_W'(trial - {1'b0, divisor_q}) : trial[DARK_W-1:0];
      quo_q <= {quo_q[QUO_W-2:0], trial_ge};
    end
    if (cmd_i.load_out) begin
      cent_q       <= empty_q ? '0 : quo_clamp[CENT_W-1:0];
      cent_empty_q <= empty_q;
    end
  end

  assign status_o.div_last = cmd_i.div_step && (step_q == LAST_STEP);
  assign centroid_q8_o     = cent_q;
  assign empty_frame_o     = cent_empty_q;

endmodule
